// File: sv/hrp_pkg.sv
// shared types, constants and character classes for the http request header parser
package hrp_pkg;

    localparam int LINE_COUNT_BITS_DEF = 16;
    localparam int MAX_LEN_W           = 16;
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 16'd4096;

    // byte roles
    localparam logic [3:0] ROLE_DELIM     = 4'd0;
    localparam logic [3:0] ROLE_METHOD    = 4'd1;
    localparam logic [3:0] ROLE_URL       = 4'd2;
    localparam logic [3:0] ROLE_VERSION   = 4'd3;
    localparam logic [3:0] ROLE_NAME      = 4'd4;
    localparam logic [3:0] ROLE_VALUE     = 4'd5;
    localparam logic [3:0] ROLE_VALUE_GAP = 4'd6;
    localparam logic [3:0] ROLE_CONT      = 4'd7;
    localparam logic [3:0] ROLE_CONT_GAP  = 4'd8;

    // error codes
    localparam logic [2:0] ERR_OK         = 3'd0;
    localparam logic [2:0] ERR_BAD_METHOD = 3'd1;
    localparam logic [2:0] ERR_NOT_GET    = 3'd2;
    localparam logic [2:0] ERR_REQ_SYNTAX = 3'd3;
    localparam logic [2:0] ERR_BAD_END    = 3'd4;
    localparam logic [2:0] ERR_HDR_SYNTAX = 3'd5;
    localparam logic [2:0] ERR_EMPTY_CONT = 3'd6;
    localparam logic [2:0] ERR_TOO_LONG   = 3'd7;

    // method match progress
    localparam logic [2:0] MM_START    = 3'd0;
    localparam logic [2:0] MM_GET      = 3'd3;
    localparam logic [2:0] MM_MISMATCH = 3'd4;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [18:0] {
        PH_METH0  = 19'b0000000000000000001,
        PH_METH   = 19'b0000000000000000010,
        PH_URL    = 19'b0000000000000000100,
        PH_PROTO0 = 19'b0000000000000001000,
        PH_PROTO1 = 19'b0000000000000010000,
        PH_PROTO2 = 19'b0000000000000100000,
        PH_PROTO3 = 19'b0000000000001000000,
        PH_PROTO4 = 19'b0000000000010000000,
        PH_D1     = 19'b0000000000100000000,
        PH_DOT    = 19'b0000000001000000000,
        PH_D2     = 19'b0000000010000000000,
        PH_RCR    = 19'b0000000100000000000,
        PH_RLF    = 19'b0000001000000000000,
        PH_HSTART = 19'b0000010000000000000,
        PH_HCR    = 19'b0000100000000000000,
        PH_NAME   = 19'b0001000000000000000,
        PH_NAMESP = 19'b0010000000000000000,
        PH_VALUE  = 19'b0100000000000000000,
        PH_CONT   = 19'b1000000000000000000
    } phase_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic is_upper(input logic [7:0] b);
        return (b >= 8'h41) && (b <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_token(input logic [7:0] b);
        logic alnum;
        logic extra;
        alnum = is_upper(b) || is_digit(b) || (b >= 8'h61 && b <= 8'h7A);
        extra = (b == 8'h2D) || (b == 8'h21) || (b == 8'h23) || (b == 8'h24)
             || (b == 8'h25) || (b == 8'h26) || (b == 8'h27) || (b == 8'h2A)
             || (b == 8'h2B) || (b == 8'h2E) || (b == 8'h5E) || (b == 8'h5F)
             || (b == 8'h60) || (b == 8'h7C) || (b == 8'h7E);
        return alnum || extra;
    endfunction

    // letters of GET by match position
    function automatic logic [7:0] want_letter(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = 8'h47;
            2'd1:    c = 8'h45;
            default: c = 8'h54;
        endcase
        return c;
    endfunction

endpackage

// File: sv/http_request_header_parser_core.sv
// http request line and header byte tagger, one byte per cycle when not stalled
// a byte accepted into the input register is parsed into the result register once that register is free
// throughput: one byte per cycle while out_ready does not stall the result register; the parse
// step between the input register and the result register is combinational
// reset: parser at the start of the request line, error cleared, max_line_length
// 4096, no word held in either register
module http_request_header_parser_core #(
    parameter int LINE_COUNT_BITS = hrp_pkg::LINE_COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hrp_pkg::MAX_LEN_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    input  logic                          conn_start,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [3:0]                    byte_role,
    output logic                          line_end,
    output logic                          request_done,
    output logic [2:0]                    error_code,
    output logic                          halted
);
    import hrp_pkg::*;

    localparam int CNT_W = LINE_COUNT_BITS + 1;
    localparam int CMP_W = (CNT_W > MAX_LEN_W) ? CNT_W : MAX_LEN_W;

    // configuration
    logic [MAX_LEN_W-1:0] max_len_reg;

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_conn_reg;

    // parser state
    phase_t                     phase_reg;
    logic [LINE_COUNT_BITS-1:0] line_pos_reg;
    logic                       prev_cr_reg;
    logic [2:0]                 mm_reg;
    logic                       vs_reg;
    logic                       err_latched_reg;

    // result register
    logic       out_valid_reg;
    logic [3:0] role_reg;
    logic       lend_reg;
    logic       done_reg;
    logic [2:0] err_reg;
    logic       halt_reg;

    logic advance;
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // state after an optional connection restart
    phase_t                     eff_phase;
    logic [LINE_COUNT_BITS-1:0] eff_pos;
    logic                       eff_cr;
    logic [2:0]                 eff_mm;
    logic                       eff_vs;
    logic                       eff_err;

    logic [CNT_W-1:0] count;
    logic             too_long;
    logic [7:0]       b;

    logic [3:0] role_next;
    logic       lend_next;
    logic       done_next;
    logic [2:0] err_next;
    logic       halt_next;
    phase_t     phase_next;
    logic [2:0] mm_next;
    logic       vs_next;

    logic [LINE_COUNT_BITS-1:0] line_pos_next;
    logic                       prev_cr_next;
    logic                       err_latched_next;

    always_comb
    begin
        b = s1_byte_reg;
        if (s1_conn_reg)
        begin
            eff_phase = PH_METH0;
            eff_pos   = '0;
            eff_cr    = 1'b0;
            eff_mm    = MM_START;
            eff_vs    = 1'b0;
            eff_err   = 1'b0;
        end
        else
        begin
            eff_phase = phase_reg;
            eff_pos   = line_pos_reg;
            eff_cr    = prev_cr_reg;
            eff_mm    = mm_reg;
            eff_vs    = vs_reg;
            eff_err   = err_latched_reg;
        end

        count    = CNT_W'(eff_pos) + CNT_W'(1);
        too_long = count[LINE_COUNT_BITS] || (CMP_W'(count) > CMP_W'(max_len_reg));

        role_next  = ROLE_DELIM;
        lend_next  = 1'b0;
        done_next  = 1'b0;
        err_next   = ERR_OK;
        halt_next  = 1'b0;
        phase_next = eff_phase;
        mm_next    = eff_mm;
        vs_next    = eff_vs;

        if (eff_err)
        begin
            halt_next = 1'b1;
        end
        else if (too_long)
        begin
            err_next = ERR_TOO_LONG;
        end
        else
        begin
            unique case (eff_phase)
                PH_METH0, PH_METH:
                begin
                    if (is_upper(b))
                    begin
                        role_next  = ROLE_METHOD;
                        phase_next = PH_METH;
                        if (eff_mm < MM_GET && want_letter(eff_mm[1:0]) == b)
                            mm_next = eff_mm + 3'd1;
                        else
                            mm_next = MM_MISMATCH;
                    end
                    else if (eff_phase == PH_METH && b == CH_SP)
                        phase_next = PH_URL;
                    else if (eff_phase == PH_METH0)
                        err_next = ERR_BAD_METHOD;
                    else
                        err_next = ERR_REQ_SYNTAX;
                end
                PH_URL:
                begin
                    priority if (!is_ws(b))
                        role_next = ROLE_URL;
                    else if (b == CH_SP)
                        phase_next = PH_PROTO0;
                    else
                        err_next = ERR_REQ_SYNTAX;
                end
                PH_PROTO0:
                begin
                    if (b == 8'h48) phase_next = PH_PROTO1;
                    else err_next = ERR_REQ_SYNTAX;
                end
                PH_PROTO1:
                begin
                    if (b == 8'h54) phase_next = PH_PROTO2;
                    else err_next = ERR_REQ_SYNTAX;
                end
                PH_PROTO2:
                begin
                    if (b == 8'h54) phase_next = PH_PROTO3;
                    else err_next = ERR_REQ_SYNTAX;
                end
                PH_PROTO3:
                begin
                    if (b == 8'h50) phase_next = PH_PROTO4;
                    else err_next = ERR_REQ_SYNTAX;
                end
                PH_PROTO4:
                begin
                    if (b == 8'h2F) phase_next = PH_D1;
                    else err_next = ERR_REQ_SYNTAX;
                end
                PH_D1:
                begin
                    if (is_digit(b))
                    begin
                        role_next  = ROLE_VERSION;
                        phase_next = PH_DOT;
                    end
                    else
                        err_next = ERR_REQ_SYNTAX;
                end
                PH_DOT:
                begin
                    if (b == CH_DOT)
                    begin
                        role_next  = ROLE_VERSION;
                        phase_next = PH_D2;
                    end
                    else
                        err_next = ERR_REQ_SYNTAX;
                end
                PH_D2:
                begin
                    if (is_digit(b))
                    begin
                        role_next  = ROLE_VERSION;
                        phase_next = PH_RCR;
                    end
                    else
                        err_next = ERR_REQ_SYNTAX;
                end
                PH_RCR:
                begin
                    if (b == CH_CR) phase_next = PH_RLF;
                    else err_next = ERR_BAD_END;
                end
                PH_RLF:
                begin
                    // method check comes after all syntax checks
                    priority if (b != CH_LF)
                        err_next = ERR_BAD_END;
                    else if (eff_mm != MM_GET)
                        err_next = ERR_NOT_GET;
                    else
                    begin
                        lend_next  = 1'b1;
                        phase_next = PH_HSTART;
                    end
                end
                PH_HSTART:
                begin
                    priority if (b == CH_CR)
                        phase_next = PH_HCR;
                    else if (b == CH_LF)
                        err_next = ERR_BAD_END;
                    else if (is_ws(b))
                    begin
                        role_next  = ROLE_CONT_GAP;
                        vs_next    = 1'b0;
                        phase_next = PH_CONT;
                    end
                    else if (is_token(b))
                    begin
                        role_next  = ROLE_NAME;
                        phase_next = PH_NAME;
                    end
                    else
                        err_next = ERR_HDR_SYNTAX;
                end
                PH_HCR:
                begin
                    if (b == CH_LF)
                    begin
                        lend_next  = 1'b1;
                        done_next  = 1'b1;
                        phase_next = PH_METH0;
                        mm_next    = MM_START;
                    end
                    else
                        err_next = ERR_HDR_SYNTAX;
                end
                PH_NAME, PH_NAMESP:
                begin
                    priority if (eff_phase == PH_NAME && is_token(b))
                        role_next = ROLE_NAME;
                    else if (b == CH_COLON)
                    begin
                        vs_next    = 1'b0;
                        phase_next = PH_VALUE;
                    end
                    else if (is_ws(b) && b != CH_CR && b != CH_LF)
                        phase_next = PH_NAMESP;
                    else
                        err_next = ERR_HDR_SYNTAX;
                end
                PH_VALUE:
                begin
                    if (b == CH_LF)
                    begin
                        if (eff_cr)
                        begin
                            lend_next  = 1'b1;
                            phase_next = PH_HSTART;
                        end
                        else
                            err_next = ERR_BAD_END;
                    end
                    else if (is_ws(b))
                        role_next = ROLE_VALUE_GAP;   // includes the line's cr
                    else
                    begin
                        role_next = ROLE_VALUE;
                        vs_next   = 1'b1;
                    end
                end
                PH_CONT:
                begin
                    if (b == CH_LF)
                    begin
                        priority if (!eff_cr)
                            err_next = ERR_BAD_END;
                        else if (!eff_vs)
                            err_next = ERR_EMPTY_CONT;
                        else
                        begin
                            lend_next  = 1'b1;
                            phase_next = PH_HSTART;
                        end
                    end
                    else if (is_ws(b))
                        role_next = ROLE_CONT_GAP;
                    else
                    begin
                        role_next = ROLE_CONT;
                        vs_next   = 1'b1;
                    end
                end
                default:
                    err_next = ERR_REQ_SYNTAX;
            endcase
        end

        if (err_next != ERR_OK)
        begin
            role_next = ROLE_DELIM;
            lend_next = 1'b0;
            done_next = 1'b0;
        end

        // position and cr flag only move on a byte that parsed cleanly
        if (halt_next || err_next != ERR_OK)
        begin
            line_pos_next = eff_pos;
            prev_cr_next  = eff_cr;
        end
        else
        begin
            line_pos_next = lend_next ? '0 : count[LINE_COUNT_BITS-1:0];
            prev_cr_next  = (b == CH_CR);
        end
        err_latched_next = eff_err || (err_next != ERR_OK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg     <= MAX_LEN_RESET;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_METH0;
            line_pos_reg    <= '0;
            prev_cr_reg     <= 1'b0;
            mm_reg          <= MM_START;
            vs_reg          <= 1'b0;
            err_latched_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_len_reg <= cfg_data;
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                phase_reg       <= phase_next;
                line_pos_reg    <= line_pos_next;
                prev_cr_reg     <= prev_cr_next;
                mm_reg          <= mm_next;
                vs_reg          <= vs_next;
                err_latched_reg <= err_latched_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= data_byte;
            s1_conn_reg <= conn_start;
        end
        if (advance)
        begin
            role_reg <= role_next;
            lend_reg <= lend_next;
            done_reg <= done_next;
            err_reg  <= err_next;
            halt_reg <= halt_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign byte_role    = role_reg;
    assign line_end     = lend_reg;
    assign request_done = done_reg;
    assign error_code   = err_reg;
    assign halted       = halt_reg;

    // an error word stops the parser for the next word unless it restarts
    a_error_latches: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (err_next != ERR_OK) |=> err_latched_reg)
        else $error("error word did not latch the parser");

    // a clean line end restarts the line count
    a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
        advance && lend_next |=> (line_pos_reg == '0) && !prev_cr_reg)
        else $error("line count not cleared after line end");

    // a halted word carries no role, no code and no line end
    a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && halted |-> (error_code == ERR_OK) && (byte_role == ROLE_DELIM)
            && !line_end && !request_done)
        else $error("halted word carries payload");

    // request done only on a line end
    a_done_on_lend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && request_done |-> line_end && (error_code == ERR_OK))
        else $error("request done without line end");

endmodule
